### sv/shared_page_group_table_macros.svh
// assertion macros used by the checker file
`ifndef SHARED_PAGE_GROUP_TABLE_MACROS_SVH
`define SHARED_PAGE_GROUP_TABLE_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define SPGT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spgt check failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define SPGT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spgt check failed");

`endif

### sv/spgt_pkg.sv
package spgt_pkg;

  localparam int GROUP_SLOTS     = 64;
  localparam int PAGES_PER_GROUP = 128;

  localparam int SLOT_W  = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int SCAN_W  = $clog2(GROUP_SLOTS + 1);
  localparam int PAGE_W  = (PAGES_PER_GROUP > 1) ? $clog2(PAGES_PER_GROUP) : 1;
  localparam int FILL_W  = $clog2(PAGES_PER_GROUP + 1);
  localparam int PSTORE_DEPTH = GROUP_SLOTS * (1 << PAGE_W);

  localparam int ADDR_W = 56;
  localparam int GID_W  = 15;
  localparam int CNT_W  = 8;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_QUERY  = 3'd2;
  localparam logic [2:0] OP_INC    = 3'd3;
  localparam logic [2:0] OP_DEC    = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_NOGROUP   = 3'd2;
  localparam logic [2:0] ST_TABLEFULL = 3'd3;
  localparam logic [2:0] ST_LISTFULL  = 3'd4;
  localparam logic [2:0] ST_NOID      = 3'd5;

  typedef struct packed {
    logic [2:0]        op;
    logic signed [15:0] group_id;
    logic [ADDR_W-1:0] page_addr;
  } spgt_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             found;
    logic [CNT_W-1:0] member_count;
  } spgt_out_t;

  typedef struct packed {
    logic [GID_W-1:0]  group;
    logic [CNT_W-1:0]  members;
    logic [FILL_W-1:0] fill;
  } spgt_slot_t;

endpackage

### sv/spgt_ram.sv
module spgt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/shared_page_group_table.sv
// shared page group table
// input channel in_valid / in_ready / in_data carries one operation item:
// create group, add page, query page, increment, decrement or read count.
// output channel out_valid / out_ready / out_data returns exactly one item
// per operation with status, found flag and member count.
// items are handled one at a time; in_ready is high only while idle.
// the group lookup walks the slot memory one entry per cycle, stopping at
// a match; add and query with a nonzero page address then walk the group's
// page list in the page memory, one entry per cycle. bad op codes and
// negative ids skip both walks and go straight to the response state.
// in_ready returns in the same cycle as out_valid, once the result is
// registered, so a new item is taken only after the last one has finished.
// reset clears all slot valid bits at once; page memory needs no clearing.
// a finished item sits in the output register until out_ready; the next
// item is accepted meanwhile, and a new result waits only if that register
// is still occupied.
module shared_page_group_table
  import spgt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  spgt_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output spgt_out_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_GSCAN = 5'b00010,
    S_ACT   = 5'b00100,
    S_PSCAN = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  localparam int PAW = $clog2(PSTORE_DEPTH);

  state_t             state_r, state_nxt;
  logic [GROUP_SLOTS-1:0] valid_r, valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  spgt_out_t          out_r, out_nxt;
  spgt_out_t          res_r, res_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [GID_W-1:0]   gid_r, gid_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [SCAN_W-1:0]  g_r, g_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic               free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]  free_idx_r, free_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  spgt_slot_t         ent_r, ent_nxt;
  logic [FILL_W-1:0]  p_r, p_nxt;
  logic               pchk_vld_r, pchk_vld_nxt;

  logic               slot_we, slot_re;
  logic [SLOT_W-1:0]  slot_waddr, slot_raddr;
  spgt_slot_t         slot_wdata, slot_rdata;
  logic               page_we, page_re;
  logic [PAW-1:0]     page_waddr, page_raddr;
  logic [ADDR_W-1:0]  page_rdata;

  logic               chk_match, pmatch;
  logic [CNT_W-1:0]   mem_new;

  spgt_ram #(.DEPTH(GROUP_SLOTS), .WIDTH($bits(spgt_slot_t))) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  spgt_ram #(.DEPTH(PSTORE_DEPTH), .WIDTH(ADDR_W)) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (page_waddr),
    .wdata (addr_r),
    .re    (page_re),
    .raddr (page_raddr),
    .rdata (page_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign chk_match = chk_vld_r && valid_r[chk_idx_r] && (slot_rdata.group == gid_r);
  assign pmatch    = pchk_vld_r && (page_rdata == addr_r);

  always_comb begin
    mem_new = ent_r.members;
    if (op_r == OP_INC && ent_r.members != '1) begin
      mem_new = ent_r.members + 1'b1;
    end else if (op_r == OP_DEC && ent_r.members != '0) begin
      mem_new = ent_r.members - 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    res_nxt        = res_r;
    op_nxt         = op_r;
    gid_nxt        = gid_r;
    addr_nxt       = addr_r;
    g_nxt          = g_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hit_nxt        = hit_r;
    slot_nxt       = slot_r;
    ent_nxt        = ent_r;
    p_nxt          = p_r;
    pchk_vld_nxt   = pchk_vld_r;

    slot_re    = 1'b0;
    slot_raddr = g_r[SLOT_W-1:0];
    slot_we    = 1'b0;
    slot_waddr = slot_r;
    slot_wdata = ent_r;
    page_re    = 1'b0;
    page_raddr = PAW'({slot_r, p_r[PAGE_W-1:0]});
    page_we    = 1'b0;
    page_waddr = PAW'({slot_r, ent_r.fill[PAGE_W-1:0]});

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.op;
          gid_nxt        = in_data.group_id[GID_W-1:0];
          addr_nxt       = in_data.page_addr;
          g_nxt          = '0;
          chk_vld_nxt    = 1'b0;
          free_found_nxt = 1'b0;
          if (in_data.op > OP_READ) begin
            res_nxt   = '0;
            state_nxt = S_RESP;
          end else if (in_data.group_id[15]) begin
            res_nxt   = '{status: ST_NOID, found: 1'b0, member_count: '0};
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_GSCAN;
          end
        end
      end
      S_GSCAN: begin
        if (chk_match) begin
          slot_nxt  = chk_idx_r;
          ent_nxt   = slot_rdata;
          hit_nxt   = 1'b1;
          state_nxt = S_ACT;
        end else begin
          if (chk_vld_r && !valid_r[chk_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          if (g_r < SCAN_W'(GROUP_SLOTS)) begin
            slot_re     = 1'b1;
            g_nxt       = g_r + 1'b1;
            chk_vld_nxt = 1'b1;
            chk_idx_nxt = g_r[SLOT_W-1:0];
          end else begin
            chk_vld_nxt = 1'b0;
            if (!chk_vld_r) begin
              hit_nxt   = 1'b0;
              state_nxt = S_ACT;
            end
          end
        end
      end
      S_ACT: begin
        state_nxt = S_RESP;
        priority if (op_r == OP_CREATE) begin
          if (hit_r) begin
            res_nxt = '{status: ST_DONE, found: 1'b0, member_count: ent_r.members};
          end else if (!free_found_r) begin
            res_nxt = '{status: ST_TABLEFULL, found: 1'b0, member_count: '0};
          end else begin
            slot_we    = 1'b1;
            slot_waddr = free_idx_r;
            slot_wdata = '{group: gid_r, members: '0, fill: '0};
            valid_nxt[free_idx_r] = 1'b1;
            res_nxt    = '{status: ST_DONE, found: 1'b0, member_count: '0};
          end
        end else if (!hit_r) begin
          res_nxt = '{status: ST_NOGROUP, found: 1'b0, member_count: '0};
        end else if (op_r == OP_ADD || op_r == OP_QUERY) begin
          if (addr_r == '0) begin
            res_nxt = '{status: ST_DONE, found: 1'b0, member_count: ent_r.members};
          end else begin
            p_nxt        = '0;
            pchk_vld_nxt = 1'b0;
            state_nxt    = S_PSCAN;
          end
        end else begin
          slot_we            = 1'b1;
          slot_wdata.members = mem_new;
          ent_nxt.members    = mem_new;
          res_nxt = '{status: ST_DONE, found: 1'b0, member_count: mem_new};
        end
      end
      S_PSCAN: begin
        if (pmatch) begin
          if (op_r == OP_QUERY) begin
            res_nxt = '{status: ST_DONE, found: 1'b1, member_count: ent_r.members};
          end else begin
            res_nxt = '{status: ST_DUP, found: 1'b0, member_count: ent_r.members};
          end
          state_nxt = S_RESP;
        end else if (p_r < ent_r.fill) begin
          page_re      = 1'b1;
          p_nxt        = p_r + 1'b1;
          pchk_vld_nxt = 1'b1;
        end else begin
          pchk_vld_nxt = 1'b0;
          if (!pchk_vld_r) begin
            state_nxt = S_RESP;
            if (op_r == OP_QUERY) begin
              res_nxt = '{status: ST_DONE, found: 1'b0, member_count: ent_r.members};
            end else if (ent_r.fill >= FILL_W'(PAGES_PER_GROUP)) begin
              res_nxt = '{status: ST_LISTFULL, found: 1'b0, member_count: ent_r.members};
            end else begin
              page_we         = 1'b1;
              slot_we         = 1'b1;
              slot_wdata.fill = ent_r.fill + 1'b1;
              res_nxt = '{status: ST_DONE, found: 1'b0, member_count: ent_r.members};
            end
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r        <= out_nxt;
    res_r        <= res_nxt;
    op_r         <= op_nxt;
    gid_r        <= gid_nxt;
    addr_r       <= addr_nxt;
    g_r          <= g_nxt;
    chk_vld_r    <= chk_vld_nxt;
    chk_idx_r    <= chk_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    hit_r        <= hit_nxt;
    slot_r       <= slot_nxt;
    ent_r        <= ent_nxt;
    p_r          <= p_nxt;
    pchk_vld_r   <= pchk_vld_nxt;
  end

endmodule

### sv/spgt_checker.sv
`include "shared_page_group_table_macros.svh"

module spgt_checker
  import spgt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input spgt_out_t out_data
);

  // stalled result holds
  `SPGT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // only defined status codes leave the block
  `SPGT_ASSERT_NOW(a_status_code, out_valid, out_data.status <= ST_NOID)

  // a page is reported found only on a successful query
  `SPGT_ASSERT_NOW(a_found_done, out_valid && out_data.found, out_data.status == ST_DONE)

  // no group means no count
  `SPGT_ASSERT_NOW(a_count_zero,
    out_valid && (out_data.status == ST_NOID || out_data.status == ST_NOGROUP ||
                  out_data.status == ST_TABLEFULL),
    out_data.member_count == '0)

  // one item at a time
  `SPGT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule

bind shared_page_group_table spgt_checker u_spgt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### dv/tb_shared_page_group_table.sv
`timescale 1ns / 1ps

module tb_shared_page_group_table;
  import spgt_pkg::*;

  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  localparam int TOTAL_OPS   = 1950;
  localparam int ID_POOL     = 72;
  localparam int ADDR_POOL   = 64;
  localparam int CYCLE_LIMIT = 4000000;

  localparam int RX_ALWAYS = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_WAVE   = 3;

  typedef struct packed {
    spgt_in_t  item;
    logic      fixed;
    spgt_out_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  spgt_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  spgt_out_t out_data;

  // shadow of the group table
  bit          slot_used [GROUP_SLOTS];
  logic [14:0] slot_gid  [GROUP_SLOTS];
  logic [7:0]  slot_cnt  [GROUP_SLOTS];
  int          slot_len  [GROUP_SLOTS];
  logic [55:0] slot_pages [GROUP_SLOTS][PAGES_PER_GROUP];

  spgt_out_t   replies_due [$];
  stim_row_t   stim_rows [$];
  logic [14:0] gid_pool [ID_POOL];
  logic [55:0] addr_pool [ADDR_POOL];

  int  bad_fields = 0;
  int  sent_ops = 0;
  int  burst_left = 0;
  int  cycles = 0;
  bit  valid_up = 1'b0;
  int  rx_mode = RX_ALWAYS;
  int  rx_left = 0;
  int  rx_phase = 0;

  shared_page_group_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic spgt_out_t run_group_op(input spgt_in_t it);
    spgt_out_t r;
    int s;
    int f;
    bit hit;
    r = '0;
    s = -1;
    f = -1;
    hit = 1'b0;
    if (it.op > OP_READ) return r;
    if (it.group_id[15]) begin
      r.status = ST_NOID;
      return r;
    end
    for (int i = 0; i < GROUP_SLOTS; i++)
      if (s < 0 && slot_used[i] && slot_gid[i] == it.group_id[14:0]) s = i;
    if (it.op == OP_CREATE) begin
      if (s >= 0) begin
        r.member_count = slot_cnt[s];
      end else begin
        for (int i = 0; i < GROUP_SLOTS; i++)
          if (f < 0 && !slot_used[i]) f = i;
        if (f < 0) begin
          r.status = ST_TABLEFULL;
        end else begin
          slot_used[f] = 1'b1;
          slot_gid[f] = it.group_id[14:0];
          slot_cnt[f] = '0;
          slot_len[f] = 0;
        end
      end
      return r;
    end
    if (s < 0) begin
      r.status = ST_NOGROUP;
      return r;
    end
    for (int j = 0; j < slot_len[s]; j++)
      if (slot_pages[s][j] == it.page_addr) hit = 1'b1;
    case (it.op)
      OP_ADD: begin
        if (it.page_addr != '0) begin
          if (hit) r.status = ST_DUP;
          else if (slot_len[s] >= PAGES_PER_GROUP) r.status = ST_LISTFULL;
          else begin
            slot_pages[s][slot_len[s]] = it.page_addr;
            slot_len[s]++;
          end
        end
      end
      OP_QUERY: r.found = hit && (it.page_addr != '0);
      OP_INC: if (slot_cnt[s] != 8'hff) slot_cnt[s] = slot_cnt[s] + 8'd1;
      OP_DEC: if (slot_cnt[s] != 8'h00) slot_cnt[s] = slot_cnt[s] - 8'd1;
      default: ;
    endcase
    r.member_count = slot_cnt[s];
    return r;
  endfunction

  function automatic logic [55:0] rand_page();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[55:0];
  endfunction

  function automatic spgt_in_t mk_item(input logic [2:0] op, input logic signed [15:0] gid,
                                       input logic [55:0] addr);
    spgt_in_t it;
    it.op = op;
    it.group_id = gid;
    it.page_addr = addr;
    return it;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic signed [15:0] gid,
                                  input logic [55:0] addr, input bit fixed,
                                  input logic [2:0] st, input logic fnd, input logic [7:0] cnt);
    stim_row_t row;
    row.item = mk_item(op, gid, addr);
    row.fixed = fixed;
    row.want.status = st;
    row.want.found = fnd;
    row.want.member_count = cnt;
    stim_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
    bad_fields++;
  endtask

  always @(posedge clk) begin
    spgt_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected item status", out_data.status, 0);
      end else begin
        want = replies_due.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.found !== want.found)
          report_mismatch("found", out_data.found, want.found);
        if (out_data.member_count !== want.member_count)
          report_mismatch("member_count", out_data.member_count, want.member_count);
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(RX_ALWAYS, RX_WAVE);
      rx_left <= $urandom_range(50, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
      default:   out_ready <= (rx_phase % 7) < 3;
    endcase
  end

  task automatic send_op(input spgt_in_t it, input bit fixed, input spgt_out_t want);
    spgt_out_t got;
    in_data <= it;
    if (!valid_up) begin
      in_valid <= 1'b1;
      valid_up = 1'b1;
    end
    do @(posedge clk); while (!in_ready);
    got = run_group_op(it);
    replies_due.push_back(fixed ? want : got);
    sent_ops++;
  endtask

  task automatic drop_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic sender_pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      drop_valid();
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(7, 150) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain_replies();
    drop_valid();
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic put(input logic [2:0] op, input logic signed [15:0] gid,
                     input logic [55:0] addr);
    send_op(mk_item(op, gid, addr), 1'b0, '0);
    sender_pace();
  endtask

  initial begin
    logic [55:0] kept_page;
    logic [31:0] w;
    logic signed [15:0] gid;
    logic [2:0] op;
    logic [55:0] addr;
    int pick;
    int run_len;
    bit did_fill;
    bit did_sat;

    did_fill = 1'b0;
    did_sat = 1'b0;
    gid_pool[0] = 15'd0;
    gid_pool[1] = 15'h7fff;
    for (int i = 2; i < ID_POOL; i++) begin
      w = $urandom;
      gid_pool[i] = w[14:0];
    end
    addr_pool[0] = {56{1'b1}};
    addr_pool[1] = 56'd1;
    for (int i = 2; i < ADDR_POOL; i++) addr_pool[i] = rand_page();

    // directed rows
    add_row(OP_READ,   16'sd5,      56'd0,      1'b1, ST_NOGROUP, 1'b0, 8'd0);
    add_row(OP_CREATE, -16'sd1,     56'd0,      1'b1, ST_NOID,    1'b0, 8'd0);
    add_row(OP_UNUSED_6, 16'sd3,    {56{1'b1}}, 1'b1, ST_DONE,    1'b0, 8'd0);
    add_row(OP_UNUSED_7, -16'sd1,   56'd5,      1'b1, ST_DONE,    1'b0, 8'd0);
    add_row(OP_CREATE, 16'sd0,      56'd0,      1'b1, ST_DONE,    1'b0, 8'd0);
    add_row(OP_CREATE, 16'sh7fff,   {56{1'b1}}, 1'b1, ST_DONE,    1'b0, 8'd0);
    add_row(OP_CREATE, 16'sd0,      56'd7,      1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_ADD,    16'sd0,      {56{1'b1}}, 1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_ADD,    16'sd0,      56'd1,      1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_ADD,    16'sd0,      56'd0,      1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_ADD,    16'sd0,      {56{1'b1}}, 1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_QUERY,  16'sd0,      {56{1'b1}}, 1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_QUERY,  16'sd0,      56'd0,      1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_QUERY,  16'sh7fff,   56'd1,      1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_INC,    16'sh7fff,   56'd0,      1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_INC,    16'sh7fff,   56'd0,      1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_DEC,    16'sh7fff,   56'd0,      1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_DEC,    16'sd0,      56'd0,      1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_READ,   16'sh7fff,   56'd0,      1'b0, ST_DONE,    1'b0, 8'd0);
    add_row(OP_ADD,    16'sd100,    56'd9,      1'b1, ST_NOGROUP, 1'b0, 8'd0);
    add_row(OP_QUERY,  16'sd100,    56'd9,      1'b1, ST_NOGROUP, 1'b0, 8'd0);
    add_row(OP_INC,    16'sh2aaa,   56'd0,      1'b1, ST_NOGROUP, 1'b0, 8'd0);
    add_row(OP_DEC,    16'sh5555,   56'd0,      1'b1, ST_NOGROUP, 1'b0, 8'd0);
    add_row(OP_ADD,    -16'sh8000,  56'd3,      1'b1, ST_NOID,    1'b0, 8'd0);
    add_row(OP_QUERY,  -16'sh5556,  {56{1'b1}}, 1'b1, ST_NOID,    1'b0, 8'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[k]) begin
      send_op(stim_rows[k].item, stim_rows[k].fixed, stim_rows[k].want);
      sender_pace();
    end
    drain_replies();

    while (sent_ops < TOTAL_OPS) begin
      if (!did_fill && sent_ops >= 400) begin
        // fill one page list past its end
        drain_replies();
        kept_page = rand_page();
        put(OP_ADD, 16'sh7fff, kept_page);
        for (int i = 0; i < PAGES_PER_GROUP + 2; i++) put(OP_ADD, 16'sh7fff, rand_page());
        put(OP_ADD, 16'sh7fff, kept_page);
        put(OP_ADD, 16'sh7fff, 56'd0);
        put(OP_QUERY, 16'sh7fff, kept_page);
        did_fill = 1'b1;
      end else if (!did_sat && sent_ops >= 1000) begin
        // count saturation at both ends
        for (int i = 0; i < 258; i++) put(OP_INC, 16'sd0, rand_page());
        put(OP_READ, 16'sd0, 56'd0);
        for (int i = 0; i < 4; i++) put(OP_DEC, 16'sh7fff, 56'd0);
        did_sat = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        w = $urandom;
        if (pick < 85) gid = {1'b0, gid_pool[$urandom_range(0, ID_POOL - 1)]};
        else if (pick < 90) gid = {1'b0, w[14:0]};
        else if (pick < 97) gid = $urandom_range(0, 1) ? -16'sd1 : {1'b1, w[14:0]};
        else gid = w[15:0];
        run_len = $urandom_range(1, 10);
        for (int i = 0; i < run_len; i++) begin
          if (pick >= 97) begin
            op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
          end else begin
            w = $urandom_range(0, 99);
            if (w < 15) op = OP_CREATE;
            else if (w < 45) op = OP_ADD;
            else if (w < 70) op = OP_QUERY;
            else if (w < 82) op = OP_INC;
            else if (w < 92) op = OP_DEC;
            else op = OP_READ;
          end
          w = $urandom_range(0, 99);
          if (w < 70) addr = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
          else if (w < 95) addr = rand_page();
          else addr = 56'd0;
          put(op, gid, addr);
        end
        if ($urandom_range(0, 199) == 0) drain_replies();
      end
    end

    drain_replies();
    repeat (250) @(posedge clk);
    if (bad_fields == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/spgt_pkg.sv
sv/spgt_ram.sv
sv/shared_page_group_table.sv
sv/spgt_checker.sv
dv/tb_shared_page_group_table.sv
